FILE: src/keq_pkg.sv
// ----------------------------------------------------------------------------
// keq_pkg
// Shared constants and types for the key event queue with long-press detect.
// ----------------------------------------------------------------------------
package keq_pkg;

    localparam int RING_DEPTH_DEF = 256;
    localparam int TIME_BITS_DEF  = 32;

    localparam int FUNC_W    = 3;
    localparam int KEY_W     = 3;
    localparam int GAP_W     = 8;
    localparam int HOLD_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [GAP_W-1:0]  REPEAT_GAP_RST = 8'd40;
    localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = 16'd200;

    localparam logic [KEY_W-1:0] NUM_KEYS = 3'd6;

    // request function codes
    localparam logic [FUNC_W-1:0] FN_KEY_EDGE   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POWER_EDGE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_TICK       = 3'd2;
    localparam logic [FUNC_W-1:0] FN_READ_KEY   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ_HALT  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_GAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming request
        logic commit;   // update state and load the result register
    } t_cmd;

endpackage

FILE: src/keq_ram.sv
// ----------------------------------------------------------------------------
// keq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module keq_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/keq_ctrl.sv
// ----------------------------------------------------------------------------
// keq_ctrl
// Request sequencer: accept, execute, and result register handshake.
// ----------------------------------------------------------------------------
module keq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    output keq_pkg::t_cmd  o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold here until the result register can take the result
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

FILE: src/keq_dp.sv
// ----------------------------------------------------------------------------
// keq_dp
// Datapath: ring pointers, repeat filter, tick time, power hold countdown.
// ----------------------------------------------------------------------------
module keq_dp #(
    parameter int RING_DEPTH = keq_pkg::RING_DEPTH_DEF,
    parameter int TIME_BITS  = keq_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  keq_pkg::t_cmd                  i_cmd,
    input  logic                           i_cfg_we,
    input  logic [keq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [keq_pkg::CFG_DAT_W-1:0]  i_cfg_wdata,
    input  logic [keq_pkg::FUNC_W-1:0]     i_func,
    input  logic [keq_pkg::KEY_W-1:0]      i_key_index,
    input  logic                           i_pin_level,
    output logic                           o_key_valid,
    output logic [keq_pkg::KEY_W-1:0]      o_key_value,
    output logic                           o_halt_flag,
    output logic                           o_dropped
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // latched request
    logic [keq_pkg::FUNC_W-1:0] r_func;
    logic [keq_pkg::KEY_W-1:0]  r_key;
    logic                       r_level;

    // configuration
    logic [keq_pkg::GAP_W-1:0]  r_repeat_gap;
    logic [keq_pkg::HOLD_W-1:0] r_hold_ticks;

    // queue and timing state
    logic [PTR_W-1:0]           r_read_ptr, n_read_ptr;
    logic [PTR_W-1:0]           r_write_ptr, n_write_ptr;
    logic                       r_last_vld, n_last_vld;
    logic [keq_pkg::KEY_W-1:0]  r_last_key, n_last_key;
    logic [TIME_BITS-1:0]       r_last_time, n_last_time;
    logic [TIME_BITS-1:0]       r_tick, n_tick;
    logic                       r_released, n_released;
    logic [keq_pkg::HOLD_W-1:0] r_hold, n_hold;
    logic                       r_halt, n_halt;

    // result register
    logic                       r_key_valid, n_key_valid;
    logic [keq_pkg::KEY_W-1:0]  r_key_value, n_key_value;
    logic                       r_halt_flag, n_halt_flag;
    logic                       r_dropped, n_dropped;

    logic [keq_pkg::KEY_W-1:0]  ram_rdata;
    logic                       ram_we;
    logic [TIME_BITS-1:0]       elapsed;
    logic                       repeat_hit;
    logic                       key_take;
    logic [PTR_W-1:0]           wp_next;

    assign elapsed    = r_tick - r_last_time;
    assign repeat_hit = r_last_vld && (r_key == r_last_key)
                        && (elapsed < TIME_BITS'(r_repeat_gap));
    assign key_take   = (r_func == keq_pkg::FN_KEY_EDGE) && !r_level
                        && (r_key < keq_pkg::NUM_KEYS) && !repeat_hit;
    assign wp_next    = ptr_next(r_write_ptr);
    assign ram_we     = i_cmd.commit && key_take;

    // read address is the read pointer, which only moves on commit, so the
    // registered data is valid by the execute cycle
    keq_ram #(
        .WIDTH (keq_pkg::KEY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_write_ptr),
        .i_wdata (r_key),
        .i_raddr (r_read_ptr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_read_ptr  = r_read_ptr;
        n_write_ptr = r_write_ptr;
        n_last_vld  = r_last_vld;
        n_last_key  = r_last_key;
        n_last_time = r_last_time;
        n_tick      = r_tick;
        n_released  = r_released;
        n_hold      = r_hold;
        n_halt      = r_halt;
        n_key_valid = 1'b0;
        n_key_value = '0;
        n_halt_flag = 1'b0;
        n_dropped   = 1'b0;
        case (r_func)
            keq_pkg::FN_KEY_EDGE: begin
                if (key_take) begin
                    n_write_ptr = wp_next;
                    n_last_vld  = 1'b1;
                    n_last_key  = r_key;
                    n_last_time = r_tick;
                    // ring full: drop the oldest entry
                    if (wp_next == r_read_ptr) begin
                        n_read_ptr = ptr_next(r_read_ptr);
                        n_dropped  = 1'b1;
                    end
                end
            end
            keq_pkg::FN_POWER_EDGE: begin
                if (r_level) begin
                    if (r_released) begin
                        n_hold     = (r_hold_ticks == '0) ? keq_pkg::HOLD_W'(1)
                                                          : r_hold_ticks;
                        n_released = 1'b0;
                    end
                end else begin
                    n_hold     = '0;
                    n_released = 1'b1;
                end
            end
            keq_pkg::FN_TICK: begin
                n_tick = r_tick + 1'b1;
                if (r_hold != '0) begin
                    n_hold = r_hold - 1'b1;
                    if ((r_hold == keq_pkg::HOLD_W'(1)) && !r_released) begin
                        n_halt = 1'b1;
                    end
                end
            end
            keq_pkg::FN_READ_KEY: begin
                if (r_read_ptr != r_write_ptr) begin
                    n_key_valid = 1'b1;
                    n_key_value = ram_rdata;
                    n_read_ptr  = ptr_next(r_read_ptr);
                end
            end
            keq_pkg::FN_READ_HALT: begin
                n_halt_flag = r_halt;
                n_halt      = 1'b0;
            end
            keq_pkg::FN_CLEAR: begin
                n_read_ptr  = '0;
                n_write_ptr = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func  <= i_func;
            r_key   <= i_key_index;
            r_level <= i_pin_level;
        end
        if (i_cmd.commit) begin
            r_key_valid <= n_key_valid;
            r_key_value <= n_key_value;
            r_halt_flag <= n_halt_flag;
            r_dropped   <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_gap <= keq_pkg::REPEAT_GAP_RST;
            r_hold_ticks <= keq_pkg::HOLD_TICKS_RST;
            r_read_ptr   <= '0;
            r_write_ptr  <= '0;
            r_last_vld   <= 1'b0;
            r_last_key   <= '0;
            r_last_time  <= '0;
            r_tick       <= '0;
            r_released   <= 1'b1;
            r_hold       <= '0;
            r_halt       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    keq_pkg::CFG_REPEAT_GAP: begin
                        r_repeat_gap <= i_cfg_wdata[keq_pkg::GAP_W-1:0];
                    end
                    keq_pkg::CFG_HOLD_TICKS: begin
                        r_hold_ticks <= i_cfg_wdata[keq_pkg::HOLD_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.commit) begin
                r_read_ptr  <= n_read_ptr;
                r_write_ptr <= n_write_ptr;
                r_last_vld  <= n_last_vld;
                r_last_key  <= n_last_key;
                r_last_time <= n_last_time;
                r_tick      <= n_tick;
                r_released  <= n_released;
                r_hold      <= n_hold;
                r_halt      <= n_halt;
            end
        end
    end

    assign o_key_valid = r_key_valid;
    assign o_key_value = r_key_value;
    assign o_halt_flag = r_halt_flag;
    assign o_dropped   = r_dropped;

endmodule

FILE: src/keypad_event_queue_long_press.sv
// ----------------------------------------------------------------------------
// keypad_event_queue_long_press
// Key event queue with repeat suppression and power-key long-press halt.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one request: a key edge, a
//   power edge, a tick, a read-key, a read-halt or a clear-queue. Every
//   request produces exactly one result on the output channel
//   (o_valid / i_stall).
//   Each request is first latched (ring read data is fetched at the read
//   pointer in the same cycle), then it updates state and loads the result
//   register. The registered ring read sets this split.
//   o_valid rises when the update commits, which waits while an earlier
//   result is still held; o_stall stays high until then, so a new request
//   is taken only after the previous one has committed.
//   A new request is accepted while an earlier result still waits; if the
//   receiver stalls, the next request finishes only once the result
//   register frees up, and o_stall stays high meanwhile.
//   Configuration writes (i_cfg_we) take effect from the next cycle and are meant for
//   idle periods only.
//   Reset (synchronous, active low) empties the queue, clears the tick time,
//   disarms the hold countdown and restores repeat_gap 40, hold_ticks 200.
//   The ring storage itself is not cleared.
// ----------------------------------------------------------------------------
module keypad_event_queue_long_press #(
    parameter int RING_DEPTH = keq_pkg::RING_DEPTH_DEF,
    parameter int TIME_BITS  = keq_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [keq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [keq_pkg::CFG_DAT_W-1:0]  i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [keq_pkg::FUNC_W-1:0]     i_func,
    input  logic [keq_pkg::KEY_W-1:0]      i_key_index,
    input  logic                           i_pin_level,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_key_valid,
    output logic [keq_pkg::KEY_W-1:0]      o_key_value,
    output logic                           o_halt_flag,
    output logic                           o_dropped
);

    keq_pkg::t_cmd cmd;

    keq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    keq_dp #(
        .RING_DEPTH (RING_DEPTH),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_func      (i_func),
        .i_key_index (i_key_index),
        .i_pin_level (i_pin_level),
        .o_key_valid (o_key_valid),
        .o_key_value (o_key_value),
        .o_halt_flag (o_halt_flag),
        .o_dropped   (o_dropped)
    );

endmodule

FILE: dv/keypad_event_queue_long_press_checker.sv
// ----------------------------------------------------------------------------
// keypad_event_queue_long_press_checker
// Watches both channels of the key event queue, predicts each result and
// compares it with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module keypad_event_queue_long_press_checker
    import keq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_wdata,
    input  logic                  i_req_valid,
    input  logic                  i_req_stall,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [KEY_W-1:0]      i_key_index,
    input  logic                  i_pin_level,
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_stall,
    input  logic                  i_key_valid,
    input  logic [KEY_W-1:0]      i_key_value,
    input  logic                  i_halt_flag,
    input  logic                  i_dropped,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    localparam int         PTR_W  = $clog2(RING_DEPTH_DEF);
    localparam logic [3:0] NO_KEY = 4'd8;

    typedef struct packed {
        logic             key_valid;
        logic [KEY_W-1:0] key_value;
        logic             halt_flag;
        logic             dropped;
    } key_result_t;

    // mirror of the queue and long-press state
    logic [KEY_W-1:0]         ring [RING_DEPTH_DEF];
    logic [PTR_W-1:0]         rd_ptr;
    logic [PTR_W-1:0]         wr_ptr;
    logic [3:0]               last_key;
    logic [TIME_BITS_DEF-1:0] last_accept;
    logic [TIME_BITS_DEF-1:0] tick_cnt;
    logic                     pwr_released;
    logic [HOLD_W-1:0]        hold_left;
    logic                     halt_pending;
    logic [GAP_W-1:0]         repeat_gap;
    logic [HOLD_W-1:0]        hold_ticks;

    key_result_t result_q[$];
    key_result_t got;
    key_result_t want;
    int          n_bad;

    assign o_mismatches = n_bad;

    function automatic key_result_t predict_request(input logic [FUNC_W-1:0] fn,
                                                    input logic [KEY_W-1:0]  key,
                                                    input logic              lvl);
        key_result_t              res;
        logic [TIME_BITS_DEF-1:0] elapsed;
        res = '0;
        case (fn)
            FN_KEY_EDGE: begin
                elapsed = tick_cnt - last_accept;
                // press only; same key again inside the gap is dropped silently
                if (!lvl && key < NUM_KEYS &&
                    !({1'b0, key} == last_key && elapsed < repeat_gap)) begin
                    ring[wr_ptr] = key;
                    wr_ptr       = wr_ptr + 1'b1;
                    last_key     = {1'b0, key};
                    last_accept  = tick_cnt;
                    if (wr_ptr == rd_ptr) begin
                        rd_ptr      = rd_ptr + 1'b1;
                        res.dropped = 1'b1;
                    end
                end
            end
            FN_POWER_EDGE: begin
                if (lvl) begin
                    if (pwr_released) begin
                        hold_left    = (hold_ticks != '0) ? hold_ticks : HOLD_W'(1);
                        pwr_released = 1'b0;
                    end
                end else begin
                    hold_left    = '0;
                    pwr_released = 1'b1;
                end
            end
            FN_TICK: begin
                tick_cnt = tick_cnt + 1'b1;
                if (hold_left != '0) begin
                    hold_left = hold_left - 1'b1;
                    if (hold_left == '0 && !pwr_released)
                        halt_pending = 1'b1;
                end
            end
            FN_READ_KEY: begin
                if (rd_ptr != wr_ptr) begin
                    res.key_valid = 1'b1;
                    res.key_value = ring[rd_ptr];
                    rd_ptr        = rd_ptr + 1'b1;
                end
            end
            FN_READ_HALT: begin
                res.halt_flag = halt_pending;
                halt_pending  = 1'b0;
            end
            FN_CLEAR: begin
                rd_ptr = '0;
                wr_ptr = '0;
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_ptr       = '0;
            wr_ptr       = '0;
            last_key     = NO_KEY;
            last_accept  = '0;
            tick_cnt     = '0;
            pwr_released = 1'b1;
            hold_left    = '0;
            halt_pending = 1'b0;
            repeat_gap   = REPEAT_GAP_RST;
            hold_ticks   = HOLD_TICKS_RST;
            result_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_REPEAT_GAP)
                    repeat_gap = i_cfg_wdata[GAP_W-1:0];
                else if (i_cfg_index == CFG_HOLD_TICKS)
                    hold_ticks = i_cfg_wdata[HOLD_W-1:0];
            end
            // retire before predicting so a stray result never eats a fresh entry
            if (i_rsp_valid && !i_rsp_stall) begin
                got = '{i_key_valid, i_key_value, i_halt_flag, i_dropped};
                if (result_q.size() == 0) begin
                    if (n_bad < 10)
                        $display({"%0t: unexpected result key_valid=%0b key_value=%0d ",
                                  "halt=%0b dropped=%0b"},
                                 $realtime, got.key_valid, got.key_value, got.halt_flag,
                                 got.dropped);
                    n_bad++;
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        if (n_bad < 10)
                            $display({"%0t: result mismatch exp key_valid=%0b key_value=%0d ",
                                      "halt=%0b dropped=%0b, got %0b %0d %0b %0b"},
                                     $realtime, want.key_valid, want.key_value, want.halt_flag,
                                     want.dropped, got.key_valid, got.key_value, got.halt_flag,
                                     got.dropped);
                        n_bad++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall)
                result_q.push_back(predict_request(i_func, i_key_index, i_pin_level));
        end
        o_outstanding <= result_q.size();
    end

endmodule

FILE: dv/keypad_event_queue_long_press_tb.sv
// ----------------------------------------------------------------------------
// keypad_event_queue_long_press_tb
// Drives key, power, tick and read requests into the key event queue under
// several register settings and idle patterns; the checker scores results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module keypad_event_queue_long_press_tb;
    import keq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_wdata;
    logic                 i_valid;
    logic                 o_stall;
    logic [FUNC_W-1:0]    i_func;
    logic [KEY_W-1:0]     i_key_index;
    logic                 i_pin_level;
    logic                 o_valid;
    logic                 i_stall;
    logic                 o_key_valid;
    logic [KEY_W-1:0]     o_key_value;
    logic                 o_halt_flag;
    logic                 o_dropped;

    int mismatches;
    int outstanding;
    int cycles;
    int items_sent;
    int gap_pct;
    int stall_pct;
    logic [KEY_W-1:0] prev_key;

    keypad_event_queue_long_press dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_key_index (i_key_index),
        .i_pin_level (i_pin_level),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_key_valid (o_key_valid),
        .o_key_value (o_key_value),
        .o_halt_flag (o_halt_flag),
        .o_dropped   (o_dropped)
    );

    keypad_event_queue_long_press_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_valid   (i_valid),
        .i_req_stall   (o_stall),
        .i_func        (i_func),
        .i_key_index   (i_key_index),
        .i_pin_level   (i_pin_level),
        .i_rsp_valid   (o_valid),
        .i_rsp_stall   (i_stall),
        .i_key_valid   (o_key_valid),
        .i_key_value   (o_key_value),
        .i_halt_flag   (o_halt_flag),
        .i_dropped     (o_dropped),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // hold the request until taken; valid is only dropped for an idle gap
    task automatic send_req(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] key,
                            input logic lvl);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        i_valid     <= 1'b1;
        i_func      <= fn;
        i_key_index <= key;
        i_pin_level <= lvl;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_cfg(input logic [GAP_W-1:0] gap, input logic [HOLD_W-1:0] hold);
        wait_drained();
        // upper bits of the gap write are junk and must be ignored
        write_cfg(CFG_REPEAT_GAP, {8'($urandom_range(255)), gap});
        write_cfg(CFG_HOLD_TICKS, hold);
        i_cfg_we <= 1'b0;
    endtask

    task automatic long_press();
        int n;
        n = $urandom_range(6);
        send_req(FN_POWER_EDGE, KEY_W'($urandom_range(7)), 1'b1);
        repeat (n) send_req(FN_TICK, KEY_W'($urandom_range(7)), 1'($urandom_range(1)));
        send_req(FN_READ_HALT, KEY_W'($urandom_range(7)), 1'($urandom_range(1)));
        send_req(FN_POWER_EDGE, KEY_W'($urandom_range(7)), 1'b0);
    endtask

    task automatic random_request(input bit fill);
        int               r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(99);
        if (fill && r < 85) begin
            send_req(FN_KEY_EDGE, KEY_W'($urandom_range(5)), 1'b0);
        end else if (fill && r < 92) begin
            send_req(FN_READ_KEY, KEY_W'($urandom_range(7)), 1'($urandom_range(1)));
        end else begin
            r = $urandom_range(99);
            if (r < 28) begin
                // bias toward repeating the same key to hit the repeat window
                k = ($urandom_range(2) == 0) ? prev_key : KEY_W'($urandom_range(5));
                prev_key = k;
                send_req(FN_KEY_EDGE, k, 1'b0);
            end else if (r < 33) begin
                send_req(FN_KEY_EDGE, KEY_W'($urandom_range(5)), 1'b1);
            end else if (r < 58) begin
                send_req(FN_TICK, KEY_W'($urandom_range(7)), 1'($urandom_range(1)));
            end else if (r < 72) begin
                send_req(FN_READ_KEY, KEY_W'($urandom_range(7)), 1'($urandom_range(1)));
            end else if (r < 78) begin
                send_req(FN_POWER_EDGE, KEY_W'($urandom_range(7)), 1'($urandom_range(1)));
            end else if (r < 82) begin
                long_press();
            end else if (r < 88) begin
                send_req(FN_READ_HALT, KEY_W'($urandom_range(7)), 1'($urandom_range(1)));
            end else if (r < 91) begin
                send_req(FN_CLEAR, KEY_W'($urandom_range(7)), 1'($urandom_range(1)));
            end else if (r < 95) begin
                send_req(FN_KEY_EDGE, KEY_W'($urandom_range(6, 7)), 1'($urandom_range(1)));
            end else begin
                send_req(FUNC_W'($urandom_range(6, 7)), KEY_W'($urandom_range(7)),
                         1'($urandom_range(1)));
            end
        end
    endtask

    task automatic run_mix(input int count, input bit fill);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop) random_request(fill);
    endtask

    initial begin
        items_sent  = 0;
        gap_pct     = 0;
        stall_pct   = 0;
        prev_key    = '0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_valid     = 1'b0;
        i_func      = '0;
        i_key_index = '0;
        i_pin_level = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests at reset settings
        send_req(FN_READ_KEY, 3'd0, 1'b0);      // empty queue
        send_req(FN_READ_HALT, 3'd0, 1'b0);
        send_req(FN_KEY_EDGE, 3'd0, 1'b0);
        send_req(FN_KEY_EDGE, 3'd0, 1'b0);      // repeat inside gap
        send_req(FN_KEY_EDGE, 3'd1, 1'b1);      // key release
        send_req(FN_KEY_EDGE, 3'd6, 1'b0);      // out-of-range keys
        send_req(FN_KEY_EDGE, 3'd7, 1'b0);
        send_req(FN_KEY_EDGE, 3'd5, 1'b0);
        send_req(FN_READ_KEY, 3'd7, 1'b1);
        send_req(FN_READ_KEY, 3'd0, 1'b0);
        send_req(FN_READ_KEY, 3'd0, 1'b0);
        send_req(FN_KEY_EDGE, 3'd5, 1'b0);      // repeat still blocked after pop
        send_req(FN_CLEAR, 3'd0, 1'b0);
        send_req(FN_POWER_EDGE, 3'd0, 1'b1);
        send_req(FN_POWER_EDGE, 3'd0, 1'b1);    // second rise
        send_req(FN_TICK, 3'd0, 1'b0);
        send_req(FN_POWER_EDGE, 3'd0, 1'b0);
        send_req(FN_TICK, 3'd7, 1'b1);
        send_req(3'd6, 3'd7, 1'b1);
        send_req(3'd7, 3'd0, 1'b0);
        send_req(FN_KEY_EDGE, 3'd3, 1'b0);
        send_req(FN_CLEAR, 3'd0, 1'b0);
        send_req(FN_READ_KEY, 3'd0, 1'b0);
        send_req(FN_READ_HALT, 3'd0, 1'b1);

        // no repeat filter, mostly presses: wraps and overflows the ring
        apply_cfg(8'd0, 16'd1);
        gap_pct = 0;  stall_pct = 0;
        run_mix(350, 1'b1);

        apply_cfg(8'd255, 16'd65535);
        gap_pct = 48; stall_pct = 0;
        run_mix(250, 1'b0);

        // zero hold: halt on the first tick after a press
        apply_cfg(8'd3, 16'd0);
        gap_pct = 0;  stall_pct = 48;
        run_mix(250, 1'b0);

        apply_cfg(8'd1, 16'd5);
        gap_pct = 33; stall_pct = 33;
        run_mix(250, 1'b0);

        apply_cfg(8'd40, 16'd2);
        gap_pct = 0;  stall_pct = 0;
        run_mix(200, 1'b0);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: keypad_event_queue_long_press.f
src/keq_pkg.sv
src/keq_ram.sv
src/keq_ctrl.sv
src/keq_dp.sv
src/keypad_event_queue_long_press.sv
dv/keypad_event_queue_long_press_checker.sv
dv/keypad_event_queue_long_press_tb.sv
